### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 4'd8;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Broadcast command to every entry lane for one request.
    typedef struct packed {
        logic touch;   // key hit: make the selected entry most recent
        logic insert;  // set miss: fill the selected slot as most recent
        logic write;   // store the request value into the selected entry
    } t_lane_cmd;

endpackage

### rtl/lkvc_lane.sv
`timescale 1ns / 1ps
// One cache entry: key, value, valid bit and age, with its own key compare.
module lkvc_lane #(
    parameter int AW = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkvc_pkg::t_lane_cmd         i_cmd,
    input  logic                        i_sel,
    input  logic [AW-1:0]               i_thr,
    input  logic [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic [lkvc_pkg::DATA_W-1:0] i_value,
    output logic                        o_match,
    output logic                        o_valid,
    output logic [AW-1:0]               o_age,
    output logic [lkvc_pkg::DATA_W-1:0] o_value
);

    logic [lkvc_pkg::DATA_W-1:0] r_key;
    logic [lkvc_pkg::DATA_W-1:0] r_value;
    logic                        r_valid;
    logic [AW-1:0]               r_age;
    logic                        n_valid;
    logic [AW-1:0]               n_age;
    logic                        wr_en;

    assign o_match = r_valid && (r_key == i_key);
    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_value = r_value;

    assign wr_en = i_sel && ((i_cmd.insert) || (i_cmd.touch && i_cmd.write));

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        if (i_cmd.insert) begin
            if (i_sel) begin
                n_valid = 1'b1;
                n_age   = '0;
            end else if (r_valid) begin
                n_age = r_age + AW'(1);
            end
        end else if (i_cmd.touch) begin
            if (i_sel) begin
                n_age = '0;
            end else if (r_valid && (r_age < i_thr)) begin
                // entries younger than the touched one age by one
                n_age = r_age + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_value <= i_value;
        end
        if (i_cmd.insert && i_sel) begin
            r_key <= i_key;
        end
    end

endmodule

### rtl/lkvc_sel.sv
`timescale 1ns / 1ps
// Slot selection: hit encoder, lowest free slot and least recent slot.
module lkvc_sel #(
    parameter int ENTRIES = 8,
    parameter int AW      = 3,
    parameter int IW      = 3,
    parameter int OW      = 4
) (
    input  logic [ENTRIES-1:0] i_match,
    input  logic [ENTRIES-1:0] i_valid,
    input  logic [AW-1:0]      i_age [ENTRIES],
    input  logic [OW-1:0]      i_occ,
    input  logic               i_full,
    output logic               o_hit,
    output logic [IW-1:0]      o_hit_idx,
    output logic [IW-1:0]      o_victim_idx
);

    logic [AW-1:0] oldest_age;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] old_idx;

    // valid ages are always 0 .. occupancy-1, so the oldest is occupancy-1
    assign oldest_age = AW'(i_occ - OW'(1));

    always_comb begin
        o_hit_idx = '0;
        free_idx  = '0;
        old_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_hit_idx = IW'(i);
            end
            if (!i_valid[i]) begin
                free_idx = IW'(i);
            end
            if (i_valid[i] && (i_age[i] == oldest_age)) begin
                old_idx = IW'(i);
            end
        end
    end

    assign o_hit        = |i_match;
    assign o_victim_idx = i_full ? old_idx : free_idx;

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// A get request passes through the request register and then the result register, which drives o_done.
// Throughput: one request per cycle; busy stays low, and the key compare over all lanes and the
// age update both work from the request register.
// Sets give no result. Results cannot be stalled and last exactly one cycle.
// Reset (synchronous, active low) empties the cache and sets capacity to 8; no clearing pass.
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_op,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_store_value,
    input  logic                               i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]         i_cfg_data,
    output logic                               o_done,
    output logic                               o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = AW;
    localparam int OW = $clog2(ENTRIES + 1);

    logic                        r_req_vld;
    logic                        r_op;
    logic [lkvc_pkg::DATA_W-1:0] r_key;
    logic [lkvc_pkg::DATA_W-1:0] r_val;
    logic [lkvc_pkg::CAP_W-1:0]  r_cap;
    logic [OW-1:0]               r_occ;
    logic [OW-1:0]               n_occ;
    logic                        r_res_vld;
    logic                        r_hit;
    logic [lkvc_pkg::DATA_W-1:0] r_rdata;

    logic [ENTRIES-1:0]          lane_match;
    logic [ENTRIES-1:0]          lane_valid;
    logic [AW-1:0]               lane_age   [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] lane_value [ENTRIES];

    logic                        hit;
    logic [IW-1:0]               hit_idx;
    logic [IW-1:0]               victim_idx;
    logic [IW-1:0]               target_idx;
    logic [7:0]                  cap_eff;
    logic                        full;
    logic                        set_miss;
    lkvc_pkg::t_lane_cmd         cmd;

    assign busy = 1'b0;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= i_op;
            r_key <= i_lookup_key;
            r_val <= i_store_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // clamp capacity to 1 .. ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = 8'd1;
        end else if (8'(r_cap) > 8'(ENTRIES)) begin
            cap_eff = 8'(ENTRIES);
        end else begin
            cap_eff = 8'(r_cap);
        end
    end

    assign full     = 8'(r_occ) >= cap_eff;
    assign set_miss = r_req_vld && (r_op == lkvc_pkg::OP_SET) && !hit;

    assign cmd.touch  = r_req_vld && hit;
    assign cmd.insert = set_miss;
    assign cmd.write  = r_op == lkvc_pkg::OP_SET;

    assign target_idx = hit ? hit_idx : victim_idx;

    always_comb begin
        n_occ = r_occ;
        if (set_miss && !full) begin
            n_occ = r_occ + OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        lkvc_lane #(
            .AW(AW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (target_idx == IW'(g)),
            .i_thr   (lane_age[hit_idx]),
            .i_key   (r_key),
            .i_value (r_val),
            .o_match (lane_match[g]),
            .o_valid (lane_valid[g]),
            .o_age   (lane_age[g]),
            .o_value (lane_value[g])
        );
    end

    lkvc_sel #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .IW      (IW),
        .OW      (OW)
    ) u_sel (
        .i_match      (lane_match),
        .i_valid      (lane_valid),
        .i_age        (lane_age),
        .i_occ        (r_occ),
        .i_full       (full),
        .o_hit        (hit),
        .o_hit_idx    (hit_idx),
        .o_victim_idx (victim_idx)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_req_vld && (r_op == lkvc_pkg::OP_GET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld && (r_op == lkvc_pkg::OP_GET)) begin
            r_hit   <= hit;
            r_rdata <= hit ? lane_value[hit_idx] : lkvc_pkg::MISS_VALUE;
        end
    end

    assign o_done       = r_res_vld;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;

endmodule

### rtl/lkvc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkvc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_op,
    input logic signed [lkvc_pkg::DATA_W-1:0] i_lookup_key,
    input logic signed [lkvc_pkg::DATA_W-1:0] i_store_value,
    input logic                               o_done,
    input logic                               o_hit,
    input logic signed [lkvc_pkg::DATA_W-1:0] o_read_value
);

    // a miss always reads back all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_read_value == lkvc_pkg::MISS_VALUE))
        else $error("miss result not all ones");

    // every result comes from a get request that passed through the request and result registers
    a_done_from_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && (i_op == lkvc_pkg::OP_GET), 2))
        else $error("result without a get request");

    // a set request never produces a result
    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == lkvc_pkg::OP_SET)) |-> ##2 !o_done)
        else $error("set request produced a result");

    // a get right after a set of the same key hits with the value just stored
    a_set_then_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == lkvc_pkg::OP_SET)) ##1
        (start && !busy && (i_op == lkvc_pkg::OP_GET) &&
         (i_lookup_key == $past(i_lookup_key)))
        |-> ##2 (o_done && o_hit && (o_read_value == $past(i_store_value, 3))))
        else $error("get after set of same key did not return stored value");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_op          (i_op),
    .i_lookup_key  (i_lookup_key),
    .i_store_value (i_store_value),
    .o_done        (o_done),
    .o_hit         (o_hit),
    .o_read_value  (o_read_value)
);
